// ----- hw/rtl/csrspmv_pkg.sv -----
`default_nettype none

package csrspmv_pkg;

  // field and datapath widths
  localparam int IDX_W       = 12;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 64;
  localparam int FRAC_W      = 16;
  // index compare width, covers the largest supported store depth
  localparam int EXT_W       = 17;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // request kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // one unit of work handed from front to back
  typedef struct packed {
    logic                     is_nz;
    logic                     last;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] x_re;
    logic signed [DATA_W-1:0] x_im;
  } work_t;

endpackage

`default_nettype wire

// ----- hw/rtl/csrspmv_ram.sv -----
`default_nettype none

module csrspmv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/csrspmv_front.sv -----
`default_nettype none

module csrspmv_front #(
  parameter int VEC_DEPTH = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire csrspmv_pkg::opcode_t                 in_op,
  input  wire logic [csrspmv_pkg::IDX_W-1:0]        in_index,
  input  wire logic signed [csrspmv_pkg::DATA_W-1:0] in_re,
  input  wire logic signed [csrspmv_pkg::DATA_W-1:0] in_im,
  input  wire logic                                 in_last,
  output logic                                      push_valid,
  input  wire logic                                 push_ready,
  output csrspmv_pkg::work_t                        push_work
);

  localparam int AW = $clog2(VEC_DEPTH);
  localparam int DW = 2 * csrspmv_pkg::DATA_W;

  logic                              accept;
  logic [csrspmv_pkg::EXT_W-1:0]     idx_ext;
  logic                              in_range;
  logic                              ram_we;
  logic                              ram_re;
  logic [DW-1:0]                     ram_rdata;

  logic                              s1_valid_r, s1_valid_nxt;
  logic                              s1_is_nz_r;
  logic                              s1_last_r;
  logic                              s1_in_range_r;
  logic signed [csrspmv_pkg::DATA_W-1:0] s1_a_re_r;
  logic signed [csrspmv_pkg::DATA_W-1:0] s1_a_im_r;

  // request handshake, held off only while the staged item cannot enter the queue
  assign in_ready = !s1_valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  // classify index against the store depth
  assign idx_ext  = csrspmv_pkg::EXT_W'(in_index);
  assign in_range = idx_ext < csrspmv_pkg::EXT_W'(VEC_DEPTH);

  // in-range loads write the store, nonzeros read their column
  assign ram_we = accept && (in_op == csrspmv_pkg::OP_LOAD) && in_range;
  assign ram_re = accept && (in_op == csrspmv_pkg::OP_NONZERO);

  csrspmv_ram #(
    .WIDTH (DW),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata ({in_im, in_re}),
    .re    (ram_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // staging slot waits for the store read
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = (in_op == csrspmv_pkg::OP_NONZERO) || (in_op == csrspmv_pkg::OP_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_nz_r    <= (in_op == csrspmv_pkg::OP_NONZERO);
      s1_last_r     <= in_last;
      s1_in_range_r <= in_range;
      s1_a_re_r     <= in_re;
      s1_a_im_r     <= in_im;
    end
  end

  // out-of-range columns use a zero vector element
  assign push_valid      = s1_valid_r;
  assign push_work.is_nz = s1_is_nz_r;
  assign push_work.last  = s1_last_r;
  assign push_work.a_re  = s1_a_re_r;
  assign push_work.a_im  = s1_a_im_r;
  assign push_work.x_re  = s1_in_range_r ? ram_rdata[csrspmv_pkg::DATA_W-1:0] : '0;
  assign push_work.x_im  = s1_in_range_r ? ram_rdata[DW-1:csrspmv_pkg::DATA_W] : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/csrspmv_queue.sv -----
`default_nettype none

module csrspmv_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire csrspmv_pkg::work_t push_work,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output csrspmv_pkg::work_t      pop_work
);

  localparam int QDEPTH = 4;
  localparam int PW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);

  csrspmv_pkg::work_t slots_r [QDEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count_r != CW'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_work   = slots_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_work;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csrspmv_back.sv -----
`default_nettype none

module csrspmv_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pop_valid,
  output logic                                pop_ready,
  input  wire csrspmv_pkg::work_t             pop_work,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [csrspmv_pkg::IDX_W-1:0]       out_row,
  output logic [csrspmv_pkg::DATA_W-1:0]      out_re,
  output logic [csrspmv_pkg::DATA_W-1:0]      out_im,
  output logic                                out_clip
);

  localparam int DW = csrspmv_pkg::DATA_W;
  localparam int AW = csrspmv_pkg::ACC_W;
  localparam int PW = csrspmv_pkg::PROD_W;
  localparam int FW = csrspmv_pkg::FRAC_W;
  localparam int RW = csrspmv_pkg::IDX_W;

  logic                 adv;
  logic signed [DW-1:0] a_re, a_im, x_re, x_im;

  // multiply stage
  logic                 m1_valid_r;
  logic                 m1_is_nz_r;
  logic                 m1_last_r;
  logic signed [PW-1:0] m1_rr_r, m1_ii_r, m1_ri_r, m1_ir_r;

  // combine stage
  logic                 m2_valid_r;
  logic                 m2_is_nz_r;
  logic                 m2_last_r;
  logic [AW-1:0]        m2_dr_r, m2_di_r;

  // accumulate and output
  logic [AW-1:0]        acc_re_r, acc_re_nxt;
  logic [AW-1:0]        acc_im_r, acc_im_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [RW-1:0]        out_row_r, out_row_nxt;
  logic [DW-1:0]        out_re_r, out_re_nxt;
  logic [DW-1:0]        out_im_r, out_im_nxt;
  logic                 out_clip_r, out_clip_nxt;

  logic [AW-1:0]        sum_re, sum_im;
  logic                 ov_re, ov_im;
  logic [DW-1:0]        sat_re, sat_im;

  // whole back end moves unless a result is stuck at the output
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;

  assign a_re = pop_work.a_re;
  assign a_im = pop_work.a_im;
  assign x_re = pop_work.x_re;
  assign x_im = pop_work.x_im;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_is_nz_r <= pop_work.is_nz;
      m1_last_r  <= pop_work.last;
      m1_rr_r    <= PW'(a_re) * PW'(x_re);
      m1_ii_r    <= PW'(a_im) * PW'(x_im);
      m1_ri_r    <= PW'(a_re) * PW'(x_im);
      m1_ir_r    <= PW'(a_im) * PW'(x_re);
    end
  end

  // floor each product to Q32.16 and combine into 48-bit real and imaginary deltas
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_is_nz_r <= m1_is_nz_r;
      m2_last_r  <= m1_last_r;
      m2_dr_r    <= m1_rr_r[PW-1:FW] - m1_ii_r[PW-1:FW];
      m2_di_r    <= m1_ri_r[PW-1:FW] + m1_ir_r[PW-1:FW];
    end
  end

  // accumulate and saturate to 32 bits
  assign sum_re = acc_re_r + m2_dr_r;
  assign sum_im = acc_im_r + m2_di_r;
  assign ov_re  = !((&sum_re[AW-1:DW-1]) || !(|sum_re[AW-1:DW-1]));
  assign ov_im  = !((&sum_im[AW-1:DW-1]) || !(|sum_im[AW-1:DW-1]));
  assign sat_re = ov_re ? {sum_re[AW-1], {(DW-1){!sum_re[AW-1]}}} : sum_re[DW-1:0];
  assign sat_im = ov_im ? {sum_im[AW-1], {(DW-1){!sum_im[AW-1]}}} : sum_im[DW-1:0];

  // row accumulator, row counter and result register
  always_comb begin
    acc_re_nxt    = acc_re_r;
    acc_im_nxt    = acc_im_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_clip_nxt  = out_clip_r;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (m2_valid_r) begin
        if (m2_is_nz_r) begin
          if (m2_last_r) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = row_r;
            out_re_nxt    = sat_re;
            out_im_nxt    = sat_im;
            out_clip_nxt  = ov_re || ov_im;
            acc_re_nxt    = '0;
            acc_im_nxt    = '0;
            row_nxt       = row_r + RW'(1);
          end else begin
            acc_re_nxt = sum_re;
            acc_im_nxt = sum_im;
          end
        end else begin
          // empty row leaves the accumulator as it is
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_re_nxt    = '0;
          out_im_nxt    = '0;
          out_clip_nxt  = 1'b0;
          row_nxt       = row_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        m1_valid_r <= pop_valid;
        m2_valid_r <= m1_valid_r;
      end
      acc_re_r    <= acc_re_nxt;
      acc_im_r    <= acc_im_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= out_row_nxt;
    out_re_r   <= out_re_nxt;
    out_im_r   <= out_im_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;
  assign out_clip  = out_clip_r;

endmodule

`default_nettype wire

// ----- hw/rtl/csr_complex_spmv_row_accumulator_unit.sv -----
// Path: a load is written into the vector store at the cycle it is accepted; the nonzero or
//   empty-row request ending a row goes via staging, queue, multiply, combine to out_tvalid.
// Throughput: one request per cycle unless stalled, set by the 48-bit accumulate loop and the
//   one-read, one-write vector store; a 4-entry queue decouples the store front from the MAC.
// Reset (rst_n low, synchronous): clears accumulators, row counter, queue and valid flags.
//   The vector store is not cleared; entries are undefined until loaded.
`default_nettype none

module csr_complex_spmv_row_accumulator_unit #(
  parameter int VEC_DEPTH = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // index[11:0], value_real[43:12], value_imag[75:44], zero fill
  input  wire logic [csrspmv_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                             in_tuser,
  input  wire logic                                   in_tlast,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // row_number[11:0], sum_real[43:12], sum_imag[75:44], zero fill
  output logic [csrspmv_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // clipped[0]
  output logic                                        out_tuser
);

  localparam int IW = csrspmv_pkg::IDX_W;
  localparam int DW = csrspmv_pkg::DATA_W;

  logic                 push_valid;
  logic                 push_ready;
  csrspmv_pkg::work_t   push_work;
  logic                 pop_valid;
  logic                 pop_ready;
  csrspmv_pkg::work_t   pop_work;
  logic [IW-1:0]        out_row;
  logic [DW-1:0]        out_re;
  logic [DW-1:0]        out_im;

  // front: request intake, vector store, column read
  csrspmv_front #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (csrspmv_pkg::opcode_t'(in_tuser)),
    .in_index   (in_tdata[IW-1:0]),
    .in_re      (in_tdata[IW+DW-1:IW]),
    .in_im      (in_tdata[IW+2*DW-1:IW+DW]),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work)
  );

  csrspmv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_work   (pop_work)
  );

  // back: complex multiply, row accumulate, saturate
  csrspmv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_work  (pop_work),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (out_row),
    .out_re    (out_re),
    .out_im    (out_im),
    .out_clip  (out_tuser)
  );

  assign out_tdata = {{(csrspmv_pkg::OUT_TDATA_W - IW - 2*DW){1'b0}}, out_im, out_re, out_row};

  // intake only stalls behind a blocked push into the queue
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (push_valid && !push_ready))
    else $error("request intake stalled without a blocked queue push");

  // a blocked push keeps its work, including the store read data
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_work)))
    else $error("staged work changed while the queue was full");

  // a waiting result freezes the back end
  a_back_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !pop_ready)
    else $error("back end advanced while a result was waiting");

endmodule

`default_nettype wire
